>>> sv/mfbb_pkg.sv
// mfbb_pkg: shared constants, codes and beat types for the framebuffer blitter.
// Depends on nothing; every file but mfbb_ram imports it.
`default_nettype none
package mfbb_pkg;

	// display geometry
	localparam int DISPLAY_WIDTH  = 160;
	localparam int DISPLAY_HEIGHT = 80;
	localparam int FB_STRIDE      = DISPLAY_WIDTH / 8;
	localparam int FB_BYTES       = FB_STRIDE * DISPLAY_HEIGHT;
	localparam int FB_AW          = $clog2(FB_BYTES);

	// field widths
	localparam int OP_W   = 3;
	localparam int COORD_W = 8;
	localparam int ADDR_W = 11;
	localparam int KIND_W = 2;
	localparam int POS_W  = 14;   // full byte position before any range check

	// queue depths
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
	localparam int RQ_DEPTH = 2;
	localparam int RQ_PW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

	localparam logic [7:0] BYTE_ONES = 8'hFF;

	// input operation codes
	localparam logic [OP_W-1:0] OP_BEGIN = 3'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ  = 3'd2;
	localparam logic [OP_W-1:0] OP_SET   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	// work handed from front to back
	typedef enum logic [2:0] {
		CMD_STATUS,
		CMD_READ,
		CMD_OR,
		CMD_SET,
		CMD_CLR
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t             op;
		logic               acc;    // status beats only
		logic [POS_W-1:0]   pos;    // first byte position
		logic               ok0;    // pos inside the store
		logic               ok1;    // pos+1 inside the store
		logic [7:0]         bits0;
		logic [7:0]         bits1;
		logic               two;    // second byte follows
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              accepted;
		logic [ADDR_W-1:0] address;
		logic [7:0]        data;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

>>> sv/mfbb_ram.sv
// mfbb_ram: generic single-port RAM, one access per cycle, registered read.
// Depends on nothing.
`default_nettype none
module mfbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1600
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/mfbb_cmd_q.sv
// mfbb_cmd_q: short command queue between the front and the back.
// Depends on mfbb_pkg.
`default_nettype none
module mfbb_cmd_q
	import mfbb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	output logic      q_full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      q_empty
);

	cmd_t             ent_q [CQ_DEPTH];
	logic [CQ_PW-1:0] wr_ptr_q;
	logic [CQ_PW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CQ_CW'(CQ_DEPTH))
		else $error("command queue count overflow");

endmodule
`default_nettype wire

>>> sv/mfbb_front.sv
// mfbb_front: accepts input beats, tracks blit progress and turns each beat
// into one command for the back. Depends on mfbb_pkg.
`default_nettype none
module mfbb_front
	import mfbb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [7:0]        x_pos,
	input  wire logic [7:0]        y_pos,
	input  wire logic [7:0]        blit_width,
	input  wire logic [7:0]        blit_height,
	input  wire logic [7:0]        source_byte,
	input  wire logic [ADDR_W-1:0] read_address,
	input  wire logic              clearing,
	input  wire logic              cq_full,
	output logic                   cq_wr,
	output cmd_t                   cq_data
);

	logic       active_q;
	logic [7:0] ox_q;
	logic [7:0] oy_q;
	logic [2:0] wrem_q;   // width mod 8
	logic [7:0] rows_q;
	logic [5:0] bpr_q;
	logic [5:0] col_q;
	logic [7:0] row_q;

	logic             take;
	logic             begin_ok;
	logic [8:0]       x_end;
	logic [8:0]       y_end;
	logic [5:0]       bpr_n;
	logic [8:0]       row_sum;
	logic [POS_W-1:0] dpos;
	logic [POS_W-1:0] ppos;
	logic [7:0]       src_m;
	logic [2:0]       xoff;
	logic [6:0]       col_nx;
	logic [8:0]       row_nx;

	assign full  = cq_full || clearing;
	assign take  = push && !full;
	assign cq_wr = take;

	assign x_end    = {1'b0, x_pos} + {1'b0, blit_width};
	assign y_end    = {1'b0, y_pos} + {1'b0, blit_height};
	assign begin_ok = (x_pos <= 8'(DISPLAY_WIDTH - 1)) && (y_pos <= 8'(DISPLAY_HEIGHT - 1))
		&& (x_end <= 9'(DISPLAY_WIDTH - 1)) && (y_end <= 9'(DISPLAY_HEIGHT - 1));
	assign bpr_n    = 6'(({1'b0, blit_width} + 9'd7) >> 3);

	assign row_sum = {1'b0, oy_q} + {1'b0, row_q};
	assign dpos    = POS_W'(row_sum) * POS_W'(FB_STRIDE) + POS_W'(ox_q[7:3]) + POS_W'(col_q);
	assign ppos    = POS_W'(y_pos) * POS_W'(FB_STRIDE) + POS_W'(x_pos[7:3]);
	assign xoff    = ox_q[2:0];

	// trim unused high bits of the last byte in a row
	always_comb begin
		src_m = source_byte;
		if ((wrem_q != 3'd0) && (col_q == bpr_q - 6'd1)) begin
			src_m = source_byte & 8'((9'd1 << wrem_q) - 9'd1);
		end
	end

	assign col_nx = {1'b0, col_q} + 7'd1;
	assign row_nx = {1'b0, row_q} + 9'd1;

	always_comb begin
		cq_data       = '0;
		cq_data.op    = CMD_STATUS;
		unique case (operation)
			OP_BEGIN: begin
				cq_data.acc = begin_ok;
			end
			OP_BYTE: begin
				if (active_q) begin
					cq_data.op    = CMD_OR;
					cq_data.acc   = 1'b1;
					cq_data.pos   = dpos;
					cq_data.ok0   = dpos < POS_W'(FB_BYTES);
					cq_data.ok1   = dpos < POS_W'(FB_BYTES - 1);
					cq_data.two   = (xoff != 3'd0);
					cq_data.bits0 = 8'(src_m << xoff);
					cq_data.bits1 = src_m >> (4'd8 - {1'b0, xoff});
				end
			end
			OP_READ: begin
				cq_data.op  = CMD_READ;
				cq_data.pos = POS_W'(read_address);
				cq_data.ok0 = read_address < ADDR_W'(FB_BYTES);
			end
			OP_SET, OP_CLEAR: begin
				if ((x_pos <= 8'(DISPLAY_WIDTH - 1)) && (y_pos <= 8'(DISPLAY_HEIGHT - 1))) begin
					cq_data.op    = (operation == OP_SET) ? CMD_SET : CMD_CLR;
					cq_data.acc   = 1'b1;
					cq_data.pos   = ppos;
					cq_data.ok0   = ppos < POS_W'(FB_BYTES);
					cq_data.bits0 = 8'(9'd1 << x_pos[2:0]);
				end
			end
			default: begin
				cq_data.acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			wrem_q   <= '0;
			rows_q   <= '0;
			bpr_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (take) begin
			if (operation == OP_BEGIN) begin
				active_q <= 1'b0;
				if (begin_ok) begin
					ox_q     <= x_pos;
					oy_q     <= y_pos;
					wrem_q   <= blit_width[2:0];
					rows_q   <= blit_height;
					bpr_q    <= bpr_n;
					col_q    <= '0;
					row_q    <= '0;
					active_q <= (blit_width != 8'd0) && (blit_height != 8'd0);
				end
			end else if ((operation == OP_BYTE) && active_q) begin
				if (col_nx >= {1'b0, bpr_q}) begin
					col_q <= '0;
					row_q <= 8'(row_nx);
					if (row_nx >= {1'b0, rows_q}) begin
						active_q <= 1'b0;
					end
				end else begin
					col_q <= 6'(col_nx);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/mfbb_back.sv
// mfbb_back: runs commands against the framebuffer RAM (read-modify-write),
// clears the RAM after reset and queues result beats. Depends on mfbb_pkg, mfbb_ram.
`default_nettype none
module mfbb_back
	import mfbb_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cq_empty,
	input  wire cmd_t         cq_data,
	output logic              cq_rd,
	output logic              clearing,
	output logic              empty,
	input  wire logic         pop,
	output res_t              res_head
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_RD2
	} state_t;

	state_t           state_q;
	logic [FB_AW-1:0] clr_q;
	cmd_t             cur_q;
	logic             second_q;

	logic             ram_en;
	logic             ram_we;
	logic [FB_AW-1:0] ram_addr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	logic [POS_W-1:0] cur_pos;
	logic             cur_ok;
	logic [7:0]       cur_bits;
	logic [7:0]       base;
	logic [7:0]       new_val;
	logic             more;

	// result queue
	res_t             rq_q [RQ_DEPTH];
	logic [RQ_PW-1:0] rq_wp_q;
	logic [RQ_PW-1:0] rq_rp_q;
	logic [RQ_CW-1:0] rq_cnt_q;
	logic             rq_room;
	logic             res_push;
	res_t             res_in;
	logic             res_pop;

	mfbb_ram #(
		.WIDTH (8),
		.DEPTH (FB_BYTES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign cur_pos  = second_q ? cur_q.pos + POS_W'(1) : cur_q.pos;
	assign cur_ok   = second_q ? cur_q.ok1 : cur_q.ok0;
	assign cur_bits = second_q ? cur_q.bits1 : cur_q.bits0;
	assign base     = cur_ok ? ram_rdata : 8'd0;
	assign more     = cur_q.two && !second_q;

	always_comb begin
		unique case (cur_q.op)
			CMD_OR, CMD_SET: new_val = base | cur_bits;
			CMD_CLR:         new_val = base & (~cur_bits & BYTE_ONES);
			default:         new_val = base;
		endcase
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = cur_pos[FB_AW-1:0];
		ram_wdata = new_val;
		cq_rd     = 1'b0;
		res_push  = 1'b0;
		res_in    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = 8'd0;
			end
			ST_IDLE: begin
				if (!cq_empty) begin
					if (cq_data.op == CMD_STATUS) begin
						if (rq_room) begin
							cq_rd           = 1'b1;
							res_push        = 1'b1;
							res_in.kind     = KIND_STATUS;
							res_in.accepted = cq_data.acc;
							res_in.last     = 1'b1;
						end
					end else begin
						cq_rd    = 1'b1;
						ram_en   = cq_data.ok0;
						ram_addr = cq_data.pos[FB_AW-1:0];
					end
				end
			end
			ST_MOD: begin
				if (rq_room) begin
					res_push        = 1'b1;
					res_in.address  = cur_pos[ADDR_W-1:0];
					res_in.data     = new_val;
					res_in.last     = !more;
					if (cur_q.op == CMD_READ) begin
						res_in.kind     = KIND_READ;
						res_in.accepted = cur_q.ok0;
					end else begin
						res_in.kind     = KIND_WRITE;
						res_in.accepted = 1'b1;
						ram_en          = cur_ok;
						ram_we          = cur_ok;
					end
				end
			end
			ST_RD2: begin
				ram_en = cur_ok;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			second_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FB_AW'(FB_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cq_rd && (cq_data.op != CMD_STATUS)) begin
						second_q <= 1'b0;
						state_q  <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (rq_room) begin
						if (more) begin
							second_q <= 1'b1;
							state_q  <= ST_RD2;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RD2: begin
					state_q <= ST_MOD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cq_rd) begin
			cur_q <= cq_data;
		end
	end

	// result queue
	assign rq_room  = (rq_cnt_q != RQ_CW'(RQ_DEPTH));
	assign empty    = (rq_cnt_q == '0);
	assign res_pop  = pop && !empty;
	assign res_head = rq_q[rq_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= '0;
			rq_rp_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (res_push) begin
				rq_wp_q <= (rq_wp_q == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rq_wp_q + 1'b1;
			end
			if (res_pop) begin
				rq_rp_q <= (rq_rp_q == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rq_rp_q + 1'b1;
			end
			if (res_push && !res_pop) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (res_pop && !res_push) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wp_q] <= res_in;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> rq_cnt_q != RQ_CW'(RQ_DEPTH))
		else $error("result pushed into a full queue");

	a_rd2_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD2 |=> state_q == ST_MOD && second_q)
		else $error("second access did not follow its read");

	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cq_rd && !res_push)
		else $error("command taken during clearing pass");

endmodule
`default_nettype wire

>>> sv/mono_framebuffer_bitmap_blitter.sv
// mono_framebuffer_bitmap_blitter: top level of the 1bpp framebuffer blitter.
// Depends on mfbb_pkg, mfbb_front, mfbb_cmd_q, mfbb_back (with mfbb_ram).
//
//   channel  | handshake      | beat moves when     | payload
//   ---------+----------------+---------------------+----------------------------------
//   input    | push / full    | push && !full       | operation, x_pos, y_pos,
//            |                |                     | blit_width, blit_height,
//            |                |                     | source_byte, read_address
//   result   | empty / pop    | pop && !empty       | kind, accepted, address, data, last
//
// Back flow: status-only beats (begin, idle bitmap byte, bad op) are answered from idle;
// reads, pixel ops and aligned bitmap bytes take a RAM read, then modify/write; an
// unaligned bitmap byte touches two bytes, each read then written. One RAM port sets this.
// Reset: after arst_n releases, the back sweeps the RAM to zero, one byte a cycle, over all
// FB_BYTES (1600) bytes; full stays high for that time.
// Stalls: a 2-deep command queue lets the front keep taking beats while the back works;
// a 2-deep result queue lets the back finish a beat while the result side is stalled.
`default_nettype none
module mono_framebuffer_bitmap_blitter
	import mfbb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input queue side
	input  wire logic              push,
	output logic                   full,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [7:0]        x_pos,
	input  wire logic [7:0]        y_pos,
	input  wire logic [7:0]        blit_width,
	input  wire logic [7:0]        blit_height,
	input  wire logic [7:0]        source_byte,
	input  wire logic [ADDR_W-1:0] read_address,
	// result queue side
	output logic                   empty,
	input  wire logic              pop,
	output logic [KIND_W-1:0]      kind,
	output logic                   accepted,
	output logic [ADDR_W-1:0]      address,
	output logic [7:0]             data,
	output logic                   last
);

	// front -> queue
	logic cq_wr;
	cmd_t cq_wdata;
	logic cq_full;
	// queue -> back
	logic cq_rd;
	cmd_t cq_rdata;
	logic cq_empty;
	// back status and head result
	logic clearing;
	res_t res_head;

	// Front: classifies each beat, keeps the blit cursor (row/column), computes
	// the byte position, trims and shifts bitmap bytes.
	mfbb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.blit_width   (blit_width),
		.blit_height  (blit_height),
		.source_byte  (source_byte),
		.read_address (read_address),
		.clearing     (clearing),
		.cq_full      (cq_full),
		.cq_wr        (cq_wr),
		.cq_data      (cq_wdata)
	);

	// Decoupling queue: one command per accepted input beat.
	mfbb_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_wr),
		.wr_data (cq_wdata),
		.q_full  (cq_full),
		.rd_en   (cq_rd),
		.rd_data (cq_rdata),
		.q_empty (cq_empty)
	);

	// Back: read-modify-write on the framebuffer RAM, one or two result beats
	// per command, pushed into its own result queue.
	mfbb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_empty (cq_empty),
		.cq_data  (cq_rdata),
		.cq_rd    (cq_rd),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.res_head (res_head)
	);

	assign kind     = res_head.kind;
	assign accepted = res_head.accepted;
	assign address  = res_head.address;
	assign data     = res_head.data;
	assign last     = res_head.last;

endmodule
`default_nettype wire

>>> tb/sv/mono_framebuffer_bitmap_blitter_tb.sv
// Self-checking testbench for mono_framebuffer_bitmap_blitter: a shadow framebuffer
// predicts every result beat. Depends on mfbb_pkg and the block's RTL only.
`timescale 1ns / 1ps
module mono_framebuffer_bitmap_blitter_tb;
	import mfbb_pkg::*;

	localparam int X_MAX        = DISPLAY_WIDTH - 1;
	localparam int Y_MAX        = DISPLAY_HEIGHT - 1;
	localparam int RANDOM_BEATS = 600;
	localparam int HOLD_CYCLES  = 300;     // one long receiver stall
	localparam int HOLD_AFTER   = 150;     // result beats seen before that stall
	localparam int DRAIN_CYCLES = 40;      // quiet drain after every owed result is back
	localparam int CYCLE_LIMIT  = 400000;  // covers the clear sweep plus ~700 beats at worst-case pace
	localparam int MAX_REPORTS  = 50;

	// opcodes the block does not decode; they must give a refused status beat
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [OP_W-1:0] OP_LAST_CODE    = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [7:0]        x;
		logic [7:0]        y;
		logic [7:0]        w;
		logic [7:0]        h;
		logic [7:0]        src;
		logic [ADDR_W-1:0] raddr;
	} fb_cmd_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              pop = 1'b0;
	fb_cmd_t           tx_beat = '0;
	logic              full;
	logic              empty;
	logic [OP_W-1:0]   operation;
	logic [7:0]        x_pos;
	logic [7:0]        y_pos;
	logic [7:0]        blit_width;
	logic [7:0]        blit_height;
	logic [7:0]        source_byte;
	logic [ADDR_W-1:0] read_address;
	logic [KIND_W-1:0] kind;
	logic              accepted;
	logic [ADDR_W-1:0] address;
	logic [7:0]        data;
	logic              last;

	assign operation    = tx_beat.op;
	assign x_pos        = tx_beat.x;
	assign y_pos        = tx_beat.y;
	assign blit_width   = tx_beat.w;
	assign blit_height  = tx_beat.h;
	assign source_byte  = tx_beat.src;
	assign read_address = tx_beat.raddr;

	mono_framebuffer_bitmap_blitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.blit_width   (blit_width),
		.blit_height  (blit_height),
		.source_byte  (source_byte),
		.read_address (read_address),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.accepted     (accepted),
		.address      (address),
		.data         (data),
		.last         (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: framebuffer image plus blitter walk state.
	// Advanced once per accepted input beat, in acceptance order.
	// ------------------------------------------------------------------
	logic [7:0] shadow_fb [FB_BYTES];
	logic       blit_armed = 1'b0;
	int         org_x, org_y, bm_w, bm_rows, row_bytes, col_idx, row_idx;

	fb_cmd_t    tx_q[$];            // stimulus not yet offered
	res_t       fb_results_due[$];  // result beats still owed by the block

	int err_cnt = 0;
	int n_items = 0;
	int n_results = 0;
	int n_writes = 0;
	int n_reads = 0;
	int n_blits = 0;
	int cycle_cnt = 0;

	initial begin
		for (int i = 0; i < FB_BYTES; i++)
			shadow_fb[FB_AW'(i)] = 8'h00;   // block sweeps its store to zero after reset
	end

	function automatic void due(logic [KIND_W-1:0] k, logic acc, int addr, int val, logic fin);
		res_t r;
		r.kind     = k;
		r.accepted = acc;
		r.address  = ADDR_W'(addr);
		r.data     = 8'(val);
		r.last     = fin;
		fb_results_due.push_back(r);
		if (k == KIND_WRITE)
			n_writes++;
		else if (k == KIND_READ)
			n_reads++;
	endfunction

	// OR into the image; an address past the store leaves it alone but still reports
	function automatic logic [7:0] or_into(int addr, logic [7:0] bits);
		if (addr < FB_BYTES) begin
			shadow_fb[FB_AW'(addr)] = shadow_fb[FB_AW'(addr)] | bits;
			return shadow_fb[FB_AW'(addr)];
		end
		return bits;
	endfunction

	function automatic void shadow_fb_step(fb_cmd_t b);
		int         x, y, w, h, dpos, xoff, pos;
		logic       ok;
		logic [7:0] bits, lo, hi, pix_mask;
		x = int'(b.x);
		y = int'(b.y);
		w = int'(b.w);
		h = int'(b.h);
		case (b.op)
		OP_BEGIN: begin
			ok = (x <= X_MAX) && (y <= Y_MAX) && (x + w <= X_MAX) && (y + h <= Y_MAX);
			blit_armed = 1'b0;   // any begin cancels a blit in flight
			if (ok) begin
				org_x      = x;
				org_y      = y;
				bm_w       = w;
				bm_rows    = h;
				row_bytes  = (w + 7) / 8;
				col_idx    = 0;
				row_idx    = 0;
				blit_armed = (w != 0) && (h != 0);
				if (blit_armed)
					n_blits++;
			end
			due(KIND_STATUS, ok, 0, 0, 1'b1);
		end
		OP_BYTE: begin
			if (!blit_armed) begin
				due(KIND_STATUS, 1'b0, 0, 0, 1'b1);
			end else begin
				bits = b.src;
				// trailing pixels past the bitmap width are dropped
				if ((bm_w % 8) != 0 && col_idx == row_bytes - 1)
					bits = bits & 8'((1 << (bm_w % 8)) - 1);
				dpos = (org_y + row_idx) * FB_STRIDE + org_x / 8 + col_idx;
				xoff = org_x % 8;
				if (xoff == 0) begin
					due(KIND_WRITE, 1'b1, dpos, int'(or_into(dpos, bits)), 1'b1);
				end else begin
					lo = 8'(bits << xoff);
					hi = bits >> (8 - xoff);
					due(KIND_WRITE, 1'b1, dpos, int'(or_into(dpos, lo)), 1'b0);
					due(KIND_WRITE, 1'b1, dpos + 1, int'(or_into(dpos + 1, hi)), 1'b1);
				end
				col_idx++;
				if (col_idx >= row_bytes) begin
					col_idx = 0;
					row_idx++;
					if (row_idx >= bm_rows)
						blit_armed = 1'b0;
				end
			end
		end
		OP_READ: begin
			if (int'(b.raddr) < FB_BYTES)
				due(KIND_READ, 1'b1, int'(b.raddr), int'(shadow_fb[b.raddr]), 1'b1);
			else
				due(KIND_READ, 1'b0, int'(b.raddr), 0, 1'b1);
		end
		OP_SET, OP_CLEAR: begin
			if (x > X_MAX || y > Y_MAX) begin
				due(KIND_STATUS, 1'b0, 0, 0, 1'b1);
			end else begin
				pos      = y * FB_STRIDE + x / 8;
				pix_mask = 8'(1 << (x % 8));
				if (b.op == OP_SET)
					shadow_fb[FB_AW'(pos)] = shadow_fb[FB_AW'(pos)] | pix_mask;
				else
					shadow_fb[FB_AW'(pos)] = shadow_fb[FB_AW'(pos)] & ~pix_mask;
				due(KIND_WRITE, 1'b1, pos, int'(shadow_fb[FB_AW'(pos)]), 1'b1);
			end
		end
		default: begin
			due(KIND_STATUS, 1'b0, 0, 0, 1'b1);
		end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders. Fields an operation does not use carry random
	// values so the block is seen to ignore them.
	// ------------------------------------------------------------------
	function automatic fb_cmd_t rand_cmd();
		fb_cmd_t c;
		c.op    = OP_BEGIN;
		c.x     = 8'($urandom);
		c.y     = 8'($urandom);
		c.w     = 8'($urandom);
		c.h     = 8'($urandom);
		c.src   = 8'($urandom);
		c.raddr = ADDR_W'($urandom);
		return c;
	endfunction

	function automatic void queue_begin(int x, int y, int w, int h);
		fb_cmd_t c;
		c    = rand_cmd();
		c.op = OP_BEGIN;
		c.x  = 8'(x);
		c.y  = 8'(y);
		c.w  = 8'(w);
		c.h  = 8'(h);
		tx_q.push_back(c);
	endfunction

	function automatic void queue_byte(int src);
		fb_cmd_t c;
		c     = rand_cmd();
		c.op  = OP_BYTE;
		c.src = 8'(src);
		tx_q.push_back(c);
	endfunction

	function automatic void queue_read(int addr);
		fb_cmd_t c;
		c       = rand_cmd();
		c.op    = OP_READ;
		c.raddr = ADDR_W'(addr);
		tx_q.push_back(c);
	endfunction

	function automatic void queue_pixel(logic [OP_W-1:0] op, int x, int y);
		fb_cmd_t c;
		c    = rand_cmd();
		c.op = op;
		c.x  = 8'(x);
		c.y  = 8'(y);
		tx_q.push_back(c);
	endfunction

	function automatic void queue_op(logic [OP_W-1:0] op);
		fb_cmd_t c;
		c    = rand_cmd();
		c.op = op;
		tx_q.push_back(c);
	endfunction

	// idle draw: every third stretch of 48 beats runs back to back
	function automatic int draw_gap(int seq);
		if ((seq / 48) % 3 == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// a random pixel op, interleaved into blits or standing alone
	function automatic void queue_rand_pixel();
		logic [OP_W-1:0] op;
		int              px, py;
		op = ($urandom_range(0, 1) == 0) ? OP_SET : OP_CLEAR;
		px = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, X_MAX);
		py = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, Y_MAX);
		queue_pixel(op, px, py);
	endfunction

	// ------------------------------------------------------------------
	// Sender: offers queued beats on push/full with random gaps. During the
	// long receiver hold-off it offers back to back so the block backs up.
	// ------------------------------------------------------------------
	int      tx_wait = 0;
	int      tx_gap;
	fb_cmd_t tx_next;
	logic    rx_hold = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push    <= 1'b0;
			tx_wait <= 0;
		end else if (push && !full) begin
			shadow_fb_step(tx_beat);
			n_items++;
			tx_gap = rx_hold ? 0 : draw_gap(n_items);
			if (tx_gap == 0 && tx_q.size() != 0) begin
				tx_next = tx_q.pop_front();
				tx_beat <= tx_next;          // push stays high for the next beat
			end else begin
				push    <= 1'b0;
				tx_wait <= tx_gap;
			end
		end else if (!push) begin
			if (tx_wait != 0) begin
				tx_wait <= tx_wait - 1;
			end else if (tx_q.size() != 0) begin
				tx_next = tx_q.pop_front();
				tx_beat <= tx_next;
				push    <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: pops result beats with random gaps and checks each against
	// the oldest owed beat, field by field.
	// ------------------------------------------------------------------
	int   rx_wait = 0;
	int   rx_gap;
	res_t rx_exp;

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop     <= 1'b0;
			rx_wait <= 0;
		end else if (pop && !empty) begin
			if (fb_results_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: result beat with none expected: kind %0d address %0d data %0d",
						$time, kind, address, data);
			end else begin
				rx_exp = fb_results_due.pop_front();
				check_field("kind", int'(rx_exp.kind), int'(kind));
				check_field("accepted", int'(rx_exp.accepted), int'(accepted));
				check_field("address", int'(rx_exp.address), int'(address));
				check_field("data", int'(rx_exp.data), int'(data));
				check_field("last", int'(rx_exp.last), int'(last));
			end
			n_results++;
			rx_gap = draw_gap(n_results + 24);
			if (rx_gap != 0 || rx_hold) begin
				pop     <= 1'b0;
				rx_wait <= rx_gap;
			end
		end else if (!pop) begin
			if (rx_wait != 0)
				rx_wait <= rx_wait - 1;
			else if (!rx_hold)
				pop <= 1'b1;
		end
	end

	// one long stall of the result side, counted here
	int   hold_cnt = 0;
	logic hold_used = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold   <= 1'b0;
			hold_cnt  <= 0;
			hold_used <= 1'b0;
		end else if (rx_hold) begin
			if (hold_cnt == HOLD_CYCLES)
				rx_hold <= 1'b0;
			else
				hold_cnt <= hold_cnt + 1;
		end else if (!hold_used && n_results >= HOLD_AFTER) begin
			rx_hold   <= 1'b1;
			hold_used <= 1'b1;
		end
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d result beats still owed",
			cycle_cnt, fb_results_due.size());
		$display("mono_framebuffer_bitmap_blitter: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run.
	// ------------------------------------------------------------------
	initial begin
		int pick, bx, by, bw, bh, wmax, hmax, nbytes, last_x, last_y, stop_at;

		// directed: reads of a cleared store and past its end
		queue_read(0);
		queue_read(FB_BYTES - 1);
		queue_read(FB_BYTES);
		queue_read((1 << ADDR_W) - 1);
		// pixel ops at the corners and just outside
		queue_pixel(OP_SET, 0, 0);
		queue_pixel(OP_SET, X_MAX, Y_MAX);
		queue_pixel(OP_CLEAR, X_MAX, Y_MAX);
		queue_pixel(OP_SET, X_MAX + 1, 0);
		queue_pixel(OP_CLEAR, 255, 255);
		// bitmap byte with nothing armed
		queue_byte('hFF);
		// largest blit that fits, then cut short by a begin one pixel too wide
		queue_begin(0, 0, X_MAX, Y_MAX);
		queue_byte('hFF);
		queue_byte('h81);
		queue_begin(1, 0, X_MAX, 0);
		queue_byte('hFF);
		// zero width is accepted but draws nothing
		queue_begin(4, 10, 0, 5);
		queue_byte('h55);
		// aligned origin, width not a multiple of 8 so row ends get masked
		queue_begin(8, 2, 12, 2);
		repeat (4) queue_byte('hFF);
		// unaligned origin against the right and bottom edges
		queue_begin(150, Y_MAX - 1, 9, 1);
		repeat (2) queue_byte('hFF);
		queue_op(OP_FIRST_UNUSED);
		queue_op(OP_LAST_CODE);
		queue_read((Y_MAX - 1) * FB_STRIDE + 150 / 8);

		// random: mostly complete blits with random content, plus pixel ops,
		// reads near the last blit, out-of-range begins and stray beats
		last_x  = 0;
		last_y  = 0;
		stop_at = tx_q.size() + RANDOM_BEATS;
		while (tx_q.size() < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				bx   = $urandom_range(0, X_MAX - 1);
				by   = $urandom_range(0, Y_MAX - 1);
				wmax = (X_MAX - bx < 40) ? X_MAX - bx : 40;
				hmax = (Y_MAX - by < 4) ? Y_MAX - by : 4;
				bw   = $urandom_range(1, wmax);
				bh   = $urandom_range(1, hmax);
				if ($urandom_range(0, 9) == 0) begin
					bw = X_MAX - bx;   // a full-width row now and then
					bh = 1;
				end
				queue_begin(bx, by, bw, bh);
				nbytes = ((bw + 7) / 8) * bh;
				if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(0, nbytes - 1);   // abandoned blit
				for (int i = 0; i < nbytes; i++) begin
					if ($urandom_range(0, 11) == 0)
						queue_rand_pixel();
					if ($urandom_range(0, 5) == 0)
						queue_byte('hFF);
					else
						queue_byte($urandom_range(0, 255));
				end
				last_x = bx;
				last_y = by;
			end else if (pick < 70) begin
				queue_rand_pixel();
			end else if (pick < 85) begin
				case ($urandom_range(0, 3))
				0, 1:    queue_read((last_y + $urandom_range(0, 3)) * FB_STRIDE + last_x / 8 +
						$urandom_range(0, 5));
				2:       queue_read($urandom_range(0, FB_BYTES - 1));
				default: queue_read($urandom_range(0, (1 << ADDR_W) - 1));
				endcase
			end else if (pick < 93) begin
				queue_begin($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			end else if ($urandom_range(0, 1) == 0) begin
				queue_byte($urandom_range(0, 255));
			end else begin
				queue_op(OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// all beats offered and taken, every owed result back, then a quiet drain
		@(posedge clk);
		while (tx_q.size() != 0 || push || fb_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d input beats and %0d result beats (%0d writes, %0d reads)",
			n_items, n_results, n_writes, n_reads);
		$display("%0d blits armed, one %0d-cycle result stall, %0d cycles in all",
			n_blits, HOLD_CYCLES, cycle_cnt);
		if (err_cnt == 0 && fb_results_due.size() == 0) begin
			$display("mono_framebuffer_bitmap_blitter: match");
		end else begin
			$display("mono_framebuffer_bitmap_blitter: mismatch");
		end
		$finish;
	end

endmodule

>>> mono_framebuffer_bitmap_blitter.f
sv/mfbb_pkg.sv
sv/mfbb_ram.sv
sv/mfbb_cmd_q.sv
sv/mfbb_front.sv
sv/mfbb_back.sv
sv/mono_framebuffer_bitmap_blitter.sv
tb/sv/mono_framebuffer_bitmap_blitter_tb.sv
